// File: design/spq_pkg.sv
// spq_pkg: types and constants of the stable priority queue.
// Shared by spq_cell and stable_priority_queue; depends on nothing.
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned ID_W         = 16;
  localparam int unsigned PRIO_W       = 8;
  localparam int unsigned OCC_W        = 5;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t entry;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: design/spq_cell.sv
// spq_cell: one slot of the sorted shift register.
// Depends on spq_pkg (entry_t, cell_cmd_t).
`default_nettype none

module spq_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spq_pkg::cell_cmd_t cmd_i,
  input  wire spq_pkg::entry_t    left_i,
  input  wire logic               left_place_i,
  input  wire spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t         entry_o,
  output logic                    place_o
);
  import spq_pkg::*;

  logic              valid_q, valid_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [PRIO_W-1:0] prio_q, prio_d;

  assign entry_o = '{valid: valid_q, id: id_q, prio: prio_q};
  assign place_o = !valid_q || (prio_q < cmd_i.entry.prio);

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    prio_d  = prio_q;
    if (cmd_i.ins && place_o) begin
      if (left_place_i) begin
        valid_d = left_i.valid;
        id_d    = left_i.id;
        prio_d  = left_i.prio;
      end else begin
        valid_d = cmd_i.entry.valid;
        id_d    = cmd_i.entry.id;
        prio_d  = cmd_i.entry.prio;
      end
    end else if (cmd_i.rem) begin
      valid_d = right_i.valid;
      id_d    = right_i.id;
      prio_d  = right_i.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

endmodule

`default_nettype wire

// File: design/stable_priority_queue.sv
// stable_priority_queue: sorted shift-register priority queue, top level.
// Depends on spq_pkg and spq_cell.
//
//   port group        dir  handshake        payload
//   command           in   start, busy      kind_i, job_id_i, job_priority_i
//   result            out  valid_o strobe   status_o, out_id_o, out_priority_o,
//                                           occupancy_o
//
// One item per cycle: every cell compares its priority with the new one in
// parallel and shifts in the same edge, so the compare in each cell sets the cycle.
// The result strobes in the cycle after the item is accepted; busy stays low.
// Reset clears the valid bit of every cell and the count at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module stable_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        kind_i,
  input  wire logic [spq_pkg::ID_W-1:0]    job_id_i,
  input  wire logic [spq_pkg::PRIO_W-1:0]  job_priority_i,
  output logic                             valid_o,
  output spq_pkg::status_e                 status_o,
  output logic [spq_pkg::ID_W-1:0]         out_id_o,
  output logic [spq_pkg::PRIO_W-1:0]       out_priority_o,
  output logic [spq_pkg::OCC_W-1:0]        occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  entry_t    cell_entry [CAPACITY];
  logic      cell_place [CAPACITY];
  cell_cmd_t cmd;
  logic      accept, full, empty;

  logic [CntW-1:0]   count_q, count_d;
  logic              valid_q;
  status_e           status_q, status_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic [PRIO_W-1:0] out_prio_q, out_prio_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = cell_entry[CAPACITY-1].valid;
  assign empty  = !cell_entry[0].valid;

  assign cmd.ins   = accept && !kind_i && !full;
  assign cmd.rem   = accept && kind_i && !empty;
  assign cmd.entry = '{valid: 1'b1, id: job_id_i, prio: job_priority_i};

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_p;
    if (g == 0) begin : g_first
      assign left_e = '0;
      assign left_p = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[g-1];
      assign left_p = cell_place[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_entry[g+1];
    end
    spq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_i       (left_e),
      .left_place_i (left_p),
      .right_i      (right_e),
      .entry_o      (cell_entry[g]),
      .place_o      (cell_place[g])
    );
  end

  always_comb begin
    count_d    = count_q;
    out_id_d   = '0;
    out_prio_d = '0;
    if (kind_i) begin
      status_d = empty ? ST_EMPTY : ST_REMOVED;
    end else begin
      status_d = full ? ST_DROPPED : ST_INSERTED;
    end
    if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.rem) begin
      count_d    = count_q - CntW'(1);
      out_id_d   = cell_entry[0].id;
      out_prio_d = cell_entry[0].prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      out_id_q   <= out_id_d;
      out_prio_q <= out_prio_d;
    end
  end

  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign out_id_o       = out_id_q;
  assign out_priority_o = out_prio_q;
  assign occupancy_o    = OCC_W'(count_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_o)
    else $error("result strobe missing after accepted item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == !cell_entry[0].valid)
    else $error("count disagrees with front cell");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntW'(CAPACITY)) == cell_entry[CAPACITY-1].valid)
    else $error("count disagrees with last cell");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rem |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("remove did not lower the count");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// tb_top: self-checking bench for stable_priority_queue, with directed and random items.
// Keeps a shadow sorted queue, predicts every result and compares each strobe field by field.
// Depends on spq_pkg and the stable_priority_queue RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned CAP         = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic        KIND_INSERT = 1'b0;
  localparam logic        KIND_REMOVE = 1'b1;

  typedef struct {
    status_e           status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [OCC_W-1:0]  occ;
  } job_reply_t;

  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic              start    = 1'b0;
  logic              kind     = 1'b0;
  logic [ID_W-1:0]   job_id   = '0;
  logic [PRIO_W-1:0] job_prio = '0;

  logic              busy;
  logic              res_valid;
  status_e           res_status;
  logic [ID_W-1:0]   res_id;
  logic [PRIO_W-1:0] res_prio;
  logic [OCC_W-1:0]  res_occ;

  logic [ID_W-1:0]   shadow_id   [CAP];
  logic [PRIO_W-1:0] shadow_prio [CAP];
  int unsigned       shadow_count = 0;

  job_reply_t        predicted_replies [$];
  int unsigned       mismatches  = 0;
  int unsigned       cycle_count = 0;
  bit                idle_off    = 1'b0;

  stable_priority_queue #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind),
    .job_id_i      (job_id),
    .job_priority_i(job_prio),
    .valid_o       (res_valid),
    .status_o      (res_status),
    .out_id_o      (res_id),
    .out_priority_o(res_prio),
    .occupancy_o   (res_occ)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL stable_priority_queue");
      $finish;
    end
  end

  task automatic predict_reply(input logic k, input logic [ID_W-1:0] id,
                               input logic [PRIO_W-1:0] prio);
    job_reply_t  r;
    int unsigned pos;
    bit          found;
    r.status = ST_INSERTED;
    r.id     = '0;
    r.prio   = '0;
    if (k == KIND_INSERT) begin
      if (shadow_count >= CAP) begin
        r.status = ST_DROPPED;
      end else begin
        pos   = shadow_count;
        found = 1'b0;
        for (int i = 0; i < shadow_count; i++) begin
          if (!found && shadow_prio[i] < prio) begin
            pos   = i;
            found = 1'b1;
          end
        end
        for (int i = shadow_count; i > pos; i--) begin
          shadow_id[i]   = shadow_id[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_id[pos]   = id;
        shadow_prio[pos] = prio;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_REMOVED;
      r.id     = shadow_id[0];
      r.prio   = shadow_prio[0];
      for (int i = 0; i + 1 < shadow_count; i++) begin
        shadow_id[i]   = shadow_id[i+1];
        shadow_prio[i] = shadow_prio[i+1];
      end
      shadow_count--;
    end
    r.occ = OCC_W'(shadow_count);
    predicted_replies.push_back(r);
  endtask

  function automatic int unsigned random_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (idle_off) return 0;
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // hold start until the item is taken, then idle for a random gap
  task automatic send_item(input logic k, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio);
    int unsigned gap;
    start    <= 1'b1;
    kind     <= k;
    job_id   <= id;
    job_prio <= prio;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_reply(k, id, prio);
    gap = random_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    job_reply_t want;
    if (rst_n && res_valid !== 1'b0) begin
      if (predicted_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0d id %h prio %h occ %0d",
                   res_status, res_id, res_prio, res_occ);
      end else begin
        want = predicted_replies.pop_front();
        if (res_valid !== 1'b1 || res_status !== want.status || res_id !== want.id ||
            res_prio !== want.prio || res_occ !== want.occ) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected status %0d id %h prio %h occ %0d, got %0d %h %h %0d",
                     want.status, want.id, want.prio, want.occ,
                     res_status, res_id, res_prio, res_occ);
        end
      end
    end
  end

  task automatic test_remove_empty();
    send_item(KIND_REMOVE, 16'hFFFF, 8'hFF);
    send_item(KIND_REMOVE, 16'h0000, 8'h00);
  endtask

  task automatic test_field_extremes();
    send_item(KIND_INSERT, 16'h0000, 8'h00);
    send_item(KIND_INSERT, 16'hFFFF, 8'hFF);
    send_item(KIND_INSERT, 16'h5AA5, 8'h80);
    repeat (3) send_item(KIND_REMOVE, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_equal_priority_order();
    send_item(KIND_INSERT, 16'h000A, 8'd7);
    send_item(KIND_INSERT, 16'h000B, 8'd7);
    send_item(KIND_INSERT, 16'h000C, 8'd7);
    send_item(KIND_INSERT, 16'h000D, 8'd9);
    send_item(KIND_INSERT, 16'h000E, 8'd7);
    repeat (6) send_item(KIND_REMOVE, 16'h0000, 8'h00);
  endtask

  task automatic test_full_queue();
    for (int round = 0; round < 8; round++) begin
      idle_off = (round == 0);
      for (int i = 0; i < CAP; i++)
        send_item(KIND_INSERT, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 7)));
      repeat ($urandom_range(1, 3))
        send_item(KIND_INSERT, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      repeat (CAP + $urandom_range(1, 3))
        send_item(KIND_REMOVE, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    end
    idle_off = 1'b0;
  endtask

  task automatic test_random_mix();
    int unsigned       insert_pct;
    bit                tie_mode;
    logic              k;
    logic [PRIO_W-1:0] prio;
    for (int seg = 0; seg < 26; seg++) begin
      case ($urandom_range(0, 2))
        0:       insert_pct = 15;
        1:       insert_pct = 50;
        default: insert_pct = 85;
      endcase
      tie_mode = $urandom_range(0, 1);
      idle_off = ($urandom_range(0, 3) == 0);
      if (seg == 13) hold_until_drained();
      for (int j = 0; j < 50; j++) begin
        k = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
        if (tie_mode) begin
          case ($urandom_range(0, 3))
            0:       prio = 8'h00;
            1:       prio = 8'hFF;
            default: prio = 8'($urandom_range(100, 103));
          endcase
        end else begin
          prio = 8'($urandom_range(0, 255));
        end
        send_item(k, 16'($urandom_range(0, 65535)), prio);
      end
    end
    idle_off = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_remove_empty();
    test_field_extremes();
    test_equal_priority_order();
    hold_until_drained();
    test_full_queue();
    test_random_mix();
    hold_until_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("PASS stable_priority_queue");
    end else begin
      $display("FAIL stable_priority_queue");
    end
    $finish;
  end

endmodule

`default_nettype wire
